[rtl/txtiler_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txtiler_pkg
// Shared types, codes and texel expansion for the rgba8 4x4 block tiler.
// ----------------------------------------------------------------------------
package txtiler_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_SOURCE_FORMAT = 2'd2
    } cfg_index_t;

    // source formats
    localparam logic [2:0] FMT_RGBA8    = 3'd0;
    localparam logic [2:0] FMT_RGB8     = 3'd1;
    localparam logic [2:0] FMT_RGBA5551 = 3'd2;
    localparam logic [2:0] FMT_RGB565   = 3'd3;

    // item opcodes
    localparam logic OP_TEXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // texels as r,g,b,a from the top byte down
    localparam logic [31:0] PAD_TEXEL     = 32'h0000_00FF;
    localparam logic [31:0] MAGENTA_TEXEL = 32'hFF00_FFFF;

    // c*255/31 and c*255/63 by reciprocal multiplication, exact over the input range
    localparam logic [23:0] SCALE5_MUL = 24'd8625630;   // 255 * ceil(2^20/31)
    localparam logic [24:0] SCALE6_MUL = 25'd16977135;  // 255 * ceil(2^22/63)

    typedef struct packed {
        logic       valid;
        logic       gb;
        logic       last;
        logic [3:0] lane_ok;
    } rd_tag_t;

    function automatic logic [7:0] scale5(input logic [4:0] c);
        logic [28:0] p;
        p = 29'(c) * 29'(SCALE5_MUL);
        return p[27:20];
    endfunction

    function automatic logic [7:0] scale6(input logic [5:0] c);
        logic [29:0] p;
        p = 30'(c) * 30'(SCALE6_MUL);
        return p[29:22];
    endfunction

    function automatic logic [31:0] expand_texel(input logic [2:0] fmt,
                                                 input logic [31:0] raw);
        logic [31:0] t;
        case (fmt)
            FMT_RGBA8:    t = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            FMT_RGB8:     t = {raw[7:0], raw[15:8], raw[23:16], 8'hFF};
            FMT_RGBA5551: t = {scale5(raw[15:11]), scale5(raw[10:6]), scale5(raw[5:1]),
                               (raw[0] ? 8'hFF : 8'h00)};
            FMT_RGB565:   t = {scale5(raw[15:11]), scale6(raw[10:5]), scale5(raw[4:0]),
                               8'hFF};
            default:      t = MAGENTA_TEXEL;
        endcase
        return t;
    endfunction

endpackage

[rtl/texture_rgba8_block_tiler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_rgba8_block_tiler_unit
// Raster texel stream in, rgba8 4x4 tiled 64-bit words out, through a
// double-banked four-row band store.
// ----------------------------------------------------------------------------
// a word released by an item passes the item register, the store read register and the output queue to m_axis
// while a band is draining each item issues two reads on the one band store read port and
//   waits while the output queue lacks room; one item per cycle is taken when no band is ready
// reset: control, counters and output queue clear at once; the band store is
//   not cleared and no clearing pass runs, so items are taken right after reset
module texture_rgba8_block_tiler_unit
    import txtiler_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // [31:0] pixel_raw
    input  logic                   s_axis_tuser,   // [0] opcode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [63:0]            m_axis_tdata,   // [63:0] tiled_word
    output logic                   m_axis_tlast,   // last_word
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int TW         = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH / 4) : 1;
    localparam int XW         = TW + 2;
    localparam int AW         = TW + 3;
    localparam int RW         = $clog2(MAX_HEIGHT + 1);
    localparam int MEM_DEPTH  = 2 ** AW;
    localparam int FIFO_DEPTH = 4;
    localparam int FPW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = FPW + 1;

    // configuration
    logic [8:0]  image_width_reg;
    logic [10:0] image_height_reg;
    logic [2:0]  source_format_reg;

    // input item held while its drain slots and texel write go through
    logic        item_valid_reg;
    logic        item_op_reg;
    logic [31:0] item_texel_reg;
    logic        item_slot_reg;

    // band control
    logic [XW-1:0] write_column_reg, write_column_next;
    logic [RW-1:0] write_row_reg, write_row_next;
    logic          loading_bank_reg, loading_bank_next;
    logic [1:0]    bank_ready_reg, bank_ready_next;
    logic [2:0]    bank_rows_reg [2];
    logic [2:0]    bank_rows_next [2];
    logic [1:0]    bank_last_reg, bank_last_next;
    logic [TW-1:0] drain_tile_reg, drain_tile_next;
    logic [2:0]    drain_word_reg, drain_word_next;
    logic          draining_bank_reg, draining_bank_next;

    // band store
    logic [127:0]  band_mem [MEM_DEPTH];
    logic [127:0]  rd_data_reg;
    rd_tag_t       rd_tag_reg, rd_tag_next;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [1:0]    mem_wlane;
    logic          mem_we;

    // output queue
    logic [64:0]    fifo_mem_reg [FIFO_DEPTH];
    logic [FPW-1:0] fifo_wr_ptr_reg, fifo_rd_ptr_reg;
    logic [FCW-1:0] fifo_cnt_reg;
    logic           fifo_push, fifo_pop;
    logic [63:0]    push_word;

    logic [XW:0]   eff_width;
    logic [RW-1:0] eff_height;
    logic [XW:0]   tile_count;
    logic          can_drain, room, step_go, issue, finish, drain_done;
    logic [1:0]    ready_after_drain;
    logic [XW-1:0] col_start;
    logic [XW:0]   col_inc;
    logic [RW-1:0] row_inc;
    logic          row_end, band_end;
    logic          in_accept;

    // clamped sizes
    always_comb
    begin
        int w;
        int h;
        w = int'(image_width_reg);
        h = int'(image_height_reg);
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (h == 0)
            h = 1;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        eff_width  = (XW+1)'(w);
        eff_height = RW'(h);
        tile_count = (XW+1)'(({1'b0, eff_width} + (XW+2)'(3)) >> 2);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 9'd1;
            image_height_reg  <= 11'd1;
            source_format_reg <= FMT_RGBA8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[8:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                CFG_SOURCE_FORMAT: source_format_reg <= cfg_data[2:0];
                default:           ;
            endcase
        end
    end

    // drain slot issue and texel write
    always_comb
    begin
        logic b;
        logic [1:0] y;
        b = draining_bank_reg;
        y = drain_word_reg[1:0];

        can_drain = bank_ready_reg[b];
        room      = (fifo_cnt_reg + FCW'(rd_tag_reg.valid)) < FCW'(FIFO_DEPTH);
        step_go   = item_valid_reg && !(can_drain && !room);
        issue     = step_go && can_drain;
        finish    = step_go && (item_slot_reg || !can_drain);

        drain_done = (drain_word_reg == 3'd7) &&
                     (({1'b0, drain_tile_reg} + (TW+1)'(1)) >= (TW+1)'(tile_count));

        mem_raddr = {b, y, drain_tile_reg};

        rd_tag_next.valid = issue;
        rd_tag_next.gb    = drain_word_reg[2];
        rd_tag_next.last  = drain_done && bank_last_reg[b];
        for (int x = 0; x < 4; x++)
        begin
            rd_tag_next.lane_ok[x] = ({1'b0, drain_tile_reg, 2'(x)} < eff_width) &&
                                     ({1'b0, y} < bank_rows_reg[b]);
        end

        drain_tile_next    = drain_tile_reg;
        drain_word_next    = drain_word_reg;
        draining_bank_next = draining_bank_reg;
        ready_after_drain  = bank_ready_reg;
        if (issue)
        begin
            if (drain_done)
            begin
                ready_after_drain[b] = 1'b0;
                draining_bank_next   = ~b;
                drain_tile_next      = '0;
                drain_word_next      = '0;
            end
            else if (drain_word_reg == 3'd7)
            begin
                drain_word_next = '0;
                drain_tile_next = drain_tile_reg + TW'(1);
            end
            else
            begin
                drain_word_next = drain_word_reg + 3'd1;
            end
        end

        // texel write, after this item's drain slots
        col_start = ({1'b0, write_column_reg} >= eff_width) ? '0 : write_column_reg;
        col_inc   = {1'b0, col_start} + (XW+1)'(1);
        row_end   = col_inc >= eff_width;
        row_inc   = write_row_reg + RW'(1);
        band_end  = (row_inc[1:0] == 2'd0) || (row_inc >= eff_height);

        mem_we    = finish && (item_op_reg == OP_TEXEL) && !ready_after_drain[loading_bank_reg];
        mem_waddr = {loading_bank_reg, write_row_reg[1:0], col_start[XW-1:2]};
        mem_wlane = col_start[1:0];

        write_column_next = write_column_reg;
        write_row_next    = write_row_reg;
        loading_bank_next = loading_bank_reg;
        bank_ready_next   = ready_after_drain;
        bank_rows_next    = bank_rows_reg;
        bank_last_next    = bank_last_reg;
        if (mem_we)
        begin
            write_column_next = row_end ? '0 : col_inc[XW-1:0];
            if (row_end)
            begin
                write_row_next = row_inc;
                if (band_end)
                begin
                    bank_rows_next[loading_bank_reg]  = {1'b0, write_row_reg[1:0]} + 3'd1;
                    bank_last_next[loading_bank_reg]  = row_inc >= eff_height;
                    bank_ready_next[loading_bank_reg] = 1'b1;
                    loading_bank_next                 = ~loading_bank_reg;
                    if (row_inc >= eff_height)
                        write_row_next = '0;
                end
            end
        end
    end

    assign s_axis_tready = !item_valid_reg || finish;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            item_op_reg       <= OP_FLUSH;
            item_slot_reg     <= 1'b0;
            write_column_reg  <= '0;
            write_row_reg     <= '0;
            loading_bank_reg  <= 1'b0;
            bank_ready_reg    <= '0;
            bank_rows_reg[0]  <= '0;
            bank_rows_reg[1]  <= '0;
            bank_last_reg     <= '0;
            drain_tile_reg    <= '0;
            drain_word_reg    <= '0;
            draining_bank_reg <= 1'b0;
            rd_tag_reg        <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                item_valid_reg <= 1'b1;
                item_op_reg    <= s_axis_tuser;
                item_slot_reg  <= 1'b0;
            end
            else if (finish)
            begin
                item_valid_reg <= 1'b0;
            end
            else if (issue)
            begin
                item_slot_reg <= 1'b1;
            end
            write_column_reg  <= write_column_next;
            write_row_reg     <= write_row_next;
            loading_bank_reg  <= loading_bank_next;
            bank_ready_reg    <= bank_ready_next;
            bank_rows_reg     <= bank_rows_next;
            bank_last_reg     <= bank_last_next;
            drain_tile_reg    <= drain_tile_next;
            drain_word_reg    <= drain_word_next;
            draining_bank_reg <= draining_bank_next;
            rd_tag_reg        <= rd_tag_next;
        end
    end

    // expansion done on entry so the write cycle only addresses the store
    always_ff @(posedge clk)
    begin
        if (in_accept)
            item_texel_reg <= expand_texel(source_format_reg, s_axis_tdata);
    end

    // band store: one lane write and one row-of-four read per cycle, read first
    always_ff @(posedge clk)
    begin
        if (mem_we)
            band_mem[mem_waddr][32*mem_wlane +: 32] <= item_texel_reg;
        if (issue)
            rd_data_reg <= band_mem[mem_raddr];
    end

    // word assembly, first texel in the top bits
    always_comb
    begin
        logic [31:0] t;
        push_word = '0;
        for (int x = 0; x < 4; x++)
        begin
            t = rd_tag_reg.lane_ok[x] ? rd_data_reg[32*x +: 32] : PAD_TEXEL;
            push_word[63-16*x -: 16] = rd_tag_reg.gb ? {t[23:16], t[15:8]}
                                                     : {t[7:0], t[31:24]};
        end
    end

    assign fifo_push     = rd_tag_reg.valid;
    assign fifo_pop      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = fifo_cnt_reg != '0;
    assign m_axis_tdata  = fifo_mem_reg[fifo_rd_ptr_reg][63:0];
    assign m_axis_tlast  = fifo_mem_reg[fifo_rd_ptr_reg][64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_cnt_reg    <= '0;
        end
        else
        begin
            if (fifo_push)
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + FPW'(1);
            if (fifo_pop)
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + FPW'(1);
            if (fifo_push && !fifo_pop)
                fifo_cnt_reg <= fifo_cnt_reg + FCW'(1);
            else if (fifo_pop && !fifo_push)
                fifo_cnt_reg <= fifo_cnt_reg - FCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
            fifo_mem_reg[fifo_wr_ptr_reg] <= {rd_tag_reg.last, push_word};
    end

    // a word in flight always finds room in the queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        rd_tag_reg.valid |-> fifo_cnt_reg < FCW'(FIFO_DEPTH))
        else $error("output queue full on push");

    // a store read is only issued against a complete band
    a_read_ready: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> bank_ready_reg[mem_raddr[AW-1]])
        else $error("band read from a bank that is not ready");

    // bank 0 becomes ready only as the loading bank
    a_ready_from_loading: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bank_ready_reg[0]) |-> $past(loading_bank_reg) == 1'b0)
        else $error("bank 0 marked ready while not loading");

    // a texel write never lands in a bank still waiting to drain
    a_write_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> $past(loading_bank_reg) != $past(draining_bank_reg)
                   || !$past(bank_ready_reg[draining_bank_reg]) || $past(drain_done))
        else $error("texel written into a ready bank");

endmodule
